[hw/rtl/mctos_pkg.sv]
package mctos_pkg;

  localparam int NUM_OUT   = 5;
  localparam int DELAY_W   = 16;
  localparam int PERIOD_W  = 12;
  localparam int ELAPSED_W = 23;
  localparam int POS_W     = 4;
  localparam int LEN_W     = 5;
  localparam int ENTRY_W   = 8;
  localparam int TAB_DEPTH = 16;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_CHANNELS         = 5;
  localparam int DEF_MAX_EVENTS       = 16;
  localparam int DEF_TICKS_PER_SECOND = 1000;

  localparam logic [PERIOD_W-1:0] STRICT_PERIOD_RST = 12'd45;
  localparam logic [PERIOD_W-1:0] EXPO_PERIOD_RST   = 12'd600;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_STRICT = 2'd1,
    MODE_EXPO   = 2'd2
  } mctos_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRICT_PERIOD = 1'd0,
    REG_EXPO_PERIOD   = 1'd1
  } mctos_reg_e;

  typedef struct packed {
    logic                              strict_switch;
    logic                              expo_switch;
    logic [NUM_OUT-1:0]                off_switches;
    logic [NUM_OUT-1:0]                on_switches;
    logic [NUM_OUT-1:0][DELAY_W-1:0]   delay;
  } mctos_item_t;

  typedef struct packed {
    logic [NUM_OUT-1:0] output_bits;
    mctos_mode_e        active_mode;
  } mctos_result_t;

  typedef struct packed {
    logic                we;
    mctos_reg_e          idx;
    logic [PERIOD_W-1:0] data;
  } mctos_cfg_t;

  // Schedule times in seconds, unused entries zero.
  localparam logic [ENTRY_W-1:0] STRICT_TAB [NUM_OUT][TAB_DEPTH] = '{
    '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [LEN_W-1:0] STRICT_LEN [NUM_OUT] = '{5'd8, 5'd8, 5'd8, 5'd8, 5'd8};

  localparam logic [ENTRY_W-1:0] EXPO_TAB [NUM_OUT][TAB_DEPTH] = '{
    '{8'd0, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd150, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd55, 8'd60, 8'd75, 8'd80, 8'd100, 8'd130, 8'd150, 8'd0},
    '{8'd0, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd60, 8'd75, 8'd100, 8'd130, 8'd150, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd150, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40,
      8'd45, 8'd90, 8'd100, 8'd130, 8'd150, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [LEN_W-1:0] EXPO_LEN [NUM_OUT] = '{5'd9, 5'd15, 5'd13, 5'd9, 5'd13};

endpackage

[hw/rtl/mctos_in_stage.sv]
module mctos_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mctos_pkg::mctos_item_t item_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output mctos_pkg::mctos_item_t item_o
);

  logic                   valid_q;
  mctos_pkg::mctos_item_t item_q;
  logic                   load;

  // Hold the word while the core cannot take it.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/mctos_core.sv]
module mctos_core #(
  parameter int CHANNELS         = mctos_pkg::DEF_CHANNELS,
  parameter int MAX_EVENTS       = mctos_pkg::DEF_MAX_EVENTS,
  parameter int TICKS_PER_SECOND = mctos_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mctos_pkg::mctos_cfg_t   cfg_i,
  input  logic                    advance_i,
  input  mctos_pkg::mctos_item_t  item_i,
  output mctos_pkg::mctos_result_t result_o
);

  localparam int NumOut = mctos_pkg::NUM_OUT;
  localparam int Nch    = (CHANNELS < NumOut) ? CHANNELS : NumOut;
  localparam int EvCap  = (MAX_EVENTS < mctos_pkg::TAB_DEPTH) ? MAX_EVENTS
                                                             : mctos_pkg::TAB_DEPTH;
  localparam int TpsW   = $clog2(TICKS_PER_SECOND + 1);
  localparam int PerW   = mctos_pkg::PERIOD_W + TpsW;
  localparam int CmpW   = (PerW > mctos_pkg::ELAPSED_W) ? PerW : mctos_pkg::ELAPSED_W;

  logic [mctos_pkg::PERIOD_W-1:0] strict_period_q, expo_period_q;

  mctos_pkg::mctos_mode_e                            mode_q, mode_d;
  logic [NumOut-1:0]                                 out_q, out_d;
  logic [NumOut-1:0][mctos_pkg::DELAY_W-1:0]         cd_q, cd_d;
  logic [mctos_pkg::ELAPSED_W-1:0]                   el_q, el_d;
  logic [NumOut-1:0][mctos_pkg::POS_W-1:0]           pos_q, pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_period_q <= mctos_pkg::STRICT_PERIOD_RST;
      expo_period_q   <= mctos_pkg::EXPO_PERIOD_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        mctos_pkg::REG_STRICT_PERIOD: strict_period_q <= cfg_i.data;
        mctos_pkg::REG_EXPO_PERIOD:   expo_period_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                          entered;
    logic                          is_strict;
    logic                          reload;
    logic [mctos_pkg::LEN_W-1:0]   len;
    logic [mctos_pkg::ENTRY_W-1:0] entry;
    logic [CmpW-1:0]               when_ticks;
    logic [CmpW-1:0]               el_cmp;
    logic [CmpW-1:0]               per_ticks;
    logic [mctos_pkg::PERIOD_W-1:0] period;

    if (item_i.strict_switch) begin
      mode_d = mctos_pkg::MODE_STRICT;
    end else if (item_i.expo_switch) begin
      mode_d = mctos_pkg::MODE_EXPO;
    end else begin
      mode_d = mctos_pkg::MODE_MANUAL;
    end

    entered   = (mode_d != mode_q);
    is_strict = (mode_d == mctos_pkg::MODE_STRICT);
    out_d     = entered ? '0 : out_q;
    cd_d      = cd_q;
    el_d      = el_q;
    pos_d     = pos_q;
    reload    = 1'b0;
    len       = '0;
    entry     = '0;
    when_ticks = '0;
    el_cmp    = '0;
    per_ticks = '0;
    period    = '0;

    if (entered) begin
      if (mode_d == mctos_pkg::MODE_MANUAL) begin
        cd_d = item_i.delay;
      end else begin
        el_d  = '0;
        pos_d = '0;
      end
    end

    unique case (mode_d)
      mctos_pkg::MODE_MANUAL: begin
        for (int i = 0; i < NumOut; i++) begin
          if (i < Nch) begin
            reload = !item_i.off_switches[i] && !item_i.on_switches[i] && !entered &&
                     (cd_d[i] == '0);
            if (item_i.off_switches[i]) begin
              out_d[i] = 1'b0;
            end else if (item_i.on_switches[i]) begin
              out_d[i] = 1'b1;
            end else if (reload) begin
              out_d[i] = ~out_d[i];
            end
            if (reload) begin
              cd_d[i] = item_i.delay[i];
            end else if (!entered && (cd_d[i] != '0)) begin
              cd_d[i] = cd_d[i] - mctos_pkg::DELAY_W'(1);
            end
          end
        end
      end
      mctos_pkg::MODE_STRICT, mctos_pkg::MODE_EXPO: begin
        // Advance elapsed time, saturating at full scale.
        if (!entered && (el_d != '1)) begin
          el_d = el_d + mctos_pkg::ELAPSED_W'(1);
        end
        el_cmp = CmpW'(el_d);
        for (int i = 0; i < NumOut; i++) begin
          len = is_strict ? mctos_pkg::STRICT_LEN[i] : mctos_pkg::EXPO_LEN[i];
          if (len > mctos_pkg::LEN_W'(EvCap)) begin
            len = mctos_pkg::LEN_W'(EvCap);
          end
          entry = is_strict ? mctos_pkg::STRICT_TAB[i][pos_d[i]]
                            : mctos_pkg::EXPO_TAB[i][pos_d[i]];
          when_ticks = CmpW'(entry) * CmpW'(TICKS_PER_SECOND);
          if ((i < Nch) && ({1'b0, pos_d[i]} < len) && (when_ticks < el_cmp)) begin
            out_d[i] = ~out_d[i];
            pos_d[i] = pos_d[i] + mctos_pkg::POS_W'(1);
          end
        end
        // Restart the schedule at the end of the period.
        period    = is_strict ? strict_period_q : expo_period_q;
        per_ticks = CmpW'(period) * CmpW'(TICKS_PER_SECOND);
        if (per_ticks < el_cmp) begin
          el_d  = '0;
          pos_d = '0;
          out_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mctos_pkg::MODE_MANUAL;
      out_q  <= '0;
      cd_q   <= '0;
      el_q   <= '0;
      pos_q  <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      out_q  <= out_d;
      cd_q   <= cd_d;
      el_q   <= el_d;
      pos_q  <= pos_d;
    end
  end

  assign result_o.output_bits = out_d;
  assign result_o.active_mode = mode_d;

endmodule

[hw/rtl/multi_channel_timed_output_sequencer_unit.sv]
// Channel  Dir  Handshake            Word
// in       in   in_valid_i/stall_o   switches, off/on masks, five reload delays
// out      out  out_valid_o/stall_i  output_bits, active_mode
// cfg      in   cfg_we_i             cfg_idx_i selects period, cfg_data_i value
//
// One word per cycle sustained while out_stall_i stays low; a word passes the input
// register, then a single pass of the core, then the result register.
// Reset clears mode to manual, outputs off, countdowns expired, elapsed time and
// table positions zero; periods return to 45 s and 600 s.
// A stalled result holds in the output register while the input register still
// takes one more word; in_stall_o rises only when both are full.
module multi_channel_timed_output_sequencer_unit #(
  parameter int CHANNELS         = mctos_pkg::DEF_CHANNELS,
  parameter int MAX_EVENTS       = mctos_pkg::DEF_MAX_EVENTS,
  parameter int TICKS_PER_SECOND = mctos_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mctos_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mctos_pkg::PERIOD_W-1:0]      cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                strict_switch_i,
  input  logic                                expo_switch_i,
  input  logic [mctos_pkg::NUM_OUT-1:0]       off_switches_i,
  input  logic [mctos_pkg::NUM_OUT-1:0]       on_switches_i,
  input  logic [mctos_pkg::DELAY_W-1:0]       delay_0_i,
  input  logic [mctos_pkg::DELAY_W-1:0]       delay_1_i,
  input  logic [mctos_pkg::DELAY_W-1:0]       delay_2_i,
  input  logic [mctos_pkg::DELAY_W-1:0]       delay_3_i,
  input  logic [mctos_pkg::DELAY_W-1:0]       delay_4_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mctos_pkg::NUM_OUT-1:0]       output_bits_o,
  output logic [1:0]                          active_mode_o
);

  mctos_pkg::mctos_item_t   in_item;
  mctos_pkg::mctos_item_t   s1_item;
  mctos_pkg::mctos_cfg_t    cfg;
  mctos_pkg::mctos_result_t res_d, res_q;
  logic                     s1_valid;
  logic                     advance;
  logic                     out_valid_q;

  // Pack the input word.
  assign in_item.strict_switch = strict_switch_i;
  assign in_item.expo_switch   = expo_switch_i;
  assign in_item.off_switches  = off_switches_i;
  assign in_item.on_switches   = on_switches_i;
  assign in_item.delay[0]      = delay_0_i;
  assign in_item.delay[1]      = delay_1_i;
  assign in_item.delay[2]      = delay_2_i;
  assign in_item.delay[3]      = delay_3_i;
  assign in_item.delay[4]      = delay_4_i;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = mctos_pkg::mctos_reg_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  // Advance a registered word into the core when the result register is free
  // or being drained this cycle.
  assign advance = s1_valid && (!out_valid_q || !out_stall_i);

  mctos_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  mctos_core #(
    .CHANNELS         (CHANNELS),
    .MAX_EVENTS       (MAX_EVENTS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (s1_item),
    .result_o  (res_d)
  );

  // Result register: hold while stalled, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign output_bits_o = res_q.output_bits;
  assign active_mode_o = res_q.active_mode;

endmodule

[test/multi_channel_timed_output_sequencer_checker.sv]
module multi_channel_timed_output_sequencer_checker #(
  parameter int CHANNELS         = mctos_pkg::DEF_CHANNELS,
  parameter int MAX_EVENTS       = mctos_pkg::DEF_MAX_EVENTS,
  parameter int TICKS_PER_SECOND = mctos_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mctos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mctos_pkg::PERIOD_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            strict_switch_i,
  input  logic                            expo_switch_i,
  input  logic [mctos_pkg::NUM_OUT-1:0]   off_switches_i,
  input  logic [mctos_pkg::NUM_OUT-1:0]   on_switches_i,
  input  logic [mctos_pkg::DELAY_W-1:0]   delay_0_i,
  input  logic [mctos_pkg::DELAY_W-1:0]   delay_1_i,
  input  logic [mctos_pkg::DELAY_W-1:0]   delay_2_i,
  input  logic [mctos_pkg::DELAY_W-1:0]   delay_3_i,
  input  logic [mctos_pkg::DELAY_W-1:0]   delay_4_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [mctos_pkg::NUM_OUT-1:0]   output_bits_i,
  input  logic [1:0]                      active_mode_i,
  output int                              mismatch_count_o,
  output int                              pending_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mctos_pkg::*;

  localparam int LIVE_CH   = (CHANNELS < NUM_OUT) ? CHANNELS : NUM_OUT;
  localparam int EVENT_CAP = (MAX_EVENTS < TAB_DEPTH) ? MAX_EVENTS : TAB_DEPTH;
  localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

  // Schedule times in seconds.
  localparam int STRICT_COUNT = 8;
  localparam int STRICT_TIMES [STRICT_COUNT] = '{5, 10, 15, 20, 25, 30, 35, 40};
  localparam int EXPO_COUNT [NUM_OUT] = '{9, 15, 13, 9, 13};
  localparam int EXPO_TIMES [NUM_OUT][15] = '{
    '{0, 10, 15, 20, 25, 30, 35, 40, 150, 0, 0, 0, 0, 0, 0},
    '{0, 10, 15, 20, 25, 30, 35, 40, 55, 60, 75, 80, 100, 130, 150},
    '{0, 10, 15, 20, 25, 30, 35, 40, 60, 75, 100, 130, 150, 0, 0},
    '{0, 10, 15, 20, 25, 30, 35, 40, 150, 0, 0, 0, 0, 0, 0},
    '{0, 10, 15, 20, 25, 30, 35, 40, 45, 90, 100, 130, 150, 0, 0}
  };

  logic [PERIOD_W-1:0]  strict_period_q;
  logic [PERIOD_W-1:0]  expo_period_q;
  mctos_mode_e          mode_q;
  logic [NUM_OUT-1:0]   lamps_q;
  logic [DELAY_W-1:0]   countdown_q [NUM_OUT];
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [POS_W-1:0]     slot_q [NUM_OUT];

  mctos_result_t predicted_lamps_q [$];
  int            mismatches;

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Advance the sequencer by one tick and return the word it shows afterward.
  task automatic advance_sequencer(input mctos_item_t w, output mctos_result_t r);
    mctos_mode_e want;
    bit          entered;
    bit          strict;
    int          i;
    int          len;
    int          pos;
    longint      due;
    longint      limit;
    want = w.strict_switch ? MODE_STRICT : (w.expo_switch ? MODE_EXPO : MODE_MANUAL);
    entered = (want != mode_q);
    if (entered) begin
      mode_q  = want;
      lamps_q = '0;
      if (want == MODE_MANUAL) begin
        for (i = 0; i < NUM_OUT; i++) countdown_q[i] = w.delay[i];
      end else begin
        elapsed_q = '0;
        for (i = 0; i < NUM_OUT; i++) slot_q[i] = '0;
      end
    end
    if (mode_q == MODE_MANUAL) begin
      for (i = 0; i < LIVE_CH; i++) begin
        if (w.off_switches[i]) begin
          lamps_q[i] = 1'b0;
        end else if (w.on_switches[i]) begin
          lamps_q[i] = 1'b1;
        end else if (!entered && countdown_q[i] == 0) begin
          lamps_q[i]     = ~lamps_q[i];
          countdown_q[i] = w.delay[i];
          continue;
        end
        if (!entered && countdown_q[i] != 0) countdown_q[i] = countdown_q[i] - 1'b1;
      end
    end else begin
      strict = (mode_q == MODE_STRICT);
      if (!entered && elapsed_q != ELAPSED_TOP) elapsed_q = elapsed_q + 1'b1;
      for (i = 0; i < LIVE_CH; i++) begin
        len = strict ? STRICT_COUNT : EXPO_COUNT[i];
        if (len > EVENT_CAP) len = EVENT_CAP;
        pos = slot_q[i];
        if (pos < len) begin
          if (strict) due = longint'(STRICT_TIMES[pos]) * TICKS_PER_SECOND;
          else        due = longint'(EXPO_TIMES[i][pos]) * TICKS_PER_SECOND;
          if (due < longint'(elapsed_q)) begin
            lamps_q[i] = ~lamps_q[i];
            slot_q[i]  = slot_q[i] + 1'b1;
          end
        end
      end
      limit = longint'(strict ? strict_period_q : expo_period_q) * TICKS_PER_SECOND;
      if (limit < longint'(elapsed_q)) begin
        elapsed_q = '0;
        lamps_q   = '0;
        for (i = 0; i < NUM_OUT; i++) slot_q[i] = '0;
      end
    end
    r.output_bits = lamps_q;
    r.active_mode = mode_q;
  endtask

  always @(posedge clk_i) begin
    mctos_item_t   w;
    mctos_result_t r;
    mctos_result_t exp_r;
    if (!rst_ni) begin
      strict_period_q = STRICT_PERIOD_RST;
      expo_period_q   = EXPO_PERIOD_RST;
      mode_q          = MODE_MANUAL;
      lamps_q         = '0;
      elapsed_q       = '0;
      for (int i = 0; i < NUM_OUT; i++) begin
        countdown_q[i] = '0;
        slot_q[i]      = '0;
      end
      predicted_lamps_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (mctos_reg_e'(cfg_idx_i))
          REG_STRICT_PERIOD: strict_period_q = cfg_data_i;
          REG_EXPO_PERIOD:   expo_period_q   = cfg_data_i;
          default: ;
        endcase
      end
      // Compare before predicting so a word that shows up early is caught.
      if (out_valid_i && !out_stall_i) begin
        if (predicted_lamps_q.size() == 0) begin
          flag_mismatch("result word with nothing predicted", '0, output_bits_i);
        end else begin
          exp_r = predicted_lamps_q.pop_front();
          if (output_bits_i !== exp_r.output_bits)
            flag_mismatch("output_bits", exp_r.output_bits, output_bits_i);
          if (active_mode_i !== exp_r.active_mode)
            flag_mismatch("active_mode", exp_r.active_mode, active_mode_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        w.strict_switch = strict_switch_i;
        w.expo_switch   = expo_switch_i;
        w.off_switches  = off_switches_i;
        w.on_switches   = on_switches_i;
        w.delay[0]      = delay_0_i;
        w.delay[1]      = delay_1_i;
        w.delay[2]      = delay_2_i;
        w.delay[3]      = delay_3_i;
        w.delay[4]      = delay_4_i;
        advance_sequencer(w, r);
        predicted_lamps_q.push_back(r);
      end
    end
    mismatch_count_o <= mismatches;
    pending_words_o  <= predicted_lamps_q.size();
  end

endmodule

[test/multi_channel_timed_output_sequencer_unit_tb.sv]
module multi_channel_timed_output_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mctos_pkg::*;

  // Give up after this many cycles in which no word moves on either channel.
  localparam int QUIET_LIMIT = 2000;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [PERIOD_W-1:0]  cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic                 strict_switch_i = 1'b0;
  logic                 expo_switch_i   = 1'b0;
  logic [NUM_OUT-1:0]   off_switches_i  = '0;
  logic [NUM_OUT-1:0]   on_switches_i   = '0;
  logic [DELAY_W-1:0]   delay_0_i       = '0;
  logic [DELAY_W-1:0]   delay_1_i       = '0;
  logic [DELAY_W-1:0]   delay_2_i       = '0;
  logic [DELAY_W-1:0]   delay_3_i       = '0;
  logic [DELAY_W-1:0]   delay_4_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [NUM_OUT-1:0]   output_bits_o;
  logic [1:0]           active_mode_o;

  int mismatch_count;
  int pending_words;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int calm_left     = 0;
  int quiet_cycles  = 0;

  always #4 clk_i = ~clk_i;

  multi_channel_timed_output_sequencer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .strict_switch_i(strict_switch_i),
    .expo_switch_i  (expo_switch_i),
    .off_switches_i (off_switches_i),
    .on_switches_i  (on_switches_i),
    .delay_0_i      (delay_0_i),
    .delay_1_i      (delay_1_i),
    .delay_2_i      (delay_2_i),
    .delay_3_i      (delay_3_i),
    .delay_4_i      (delay_4_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .output_bits_o  (output_bits_o),
    .active_mode_o  (active_mode_o)
  );

  multi_channel_timed_output_sequencer_checker sequencer_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .strict_switch_i (strict_switch_i),
    .expo_switch_i   (expo_switch_i),
    .off_switches_i  (off_switches_i),
    .on_switches_i   (on_switches_i),
    .delay_0_i       (delay_0_i),
    .delay_1_i       (delay_1_i),
    .delay_2_i       (delay_2_i),
    .delay_3_i       (delay_3_i),
    .delay_4_i       (delay_4_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .output_bits_i   (output_bits_o),
    .active_mode_i   (active_mode_o),
    .mismatch_count_o(mismatch_count),
    .pending_words_o (pending_words)
  );

  // Open a calm stretch now and then: neither side idles while it lasts.
  always @(posedge clk_i) begin
    if (calm_left != 0) calm_left <= calm_left - 1;
    else if ($urandom_range(99) < 2) calm_left <= $urandom_range(20, 60);
  end

  // Receiver: stall the result channel at the current idle rate.
  always @(posedge clk_i)
    out_stall_i <= (calm_left == 0) && ($urandom_range(99) < recv_idle_pct);

  // Count cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Build a tick word with the same reload delay on every output.
  function automatic mctos_item_t directed_word(logic strict_sw, logic expo_sw,
                                                logic [NUM_OUT-1:0] offs,
                                                logic [NUM_OUT-1:0] ons,
                                                logic [DELAY_W-1:0] dly);
    mctos_item_t w;
    w.strict_switch = strict_sw;
    w.expo_switch   = expo_sw;
    w.off_switches  = offs;
    w.on_switches   = ons;
    for (int i = 0; i < NUM_OUT; i++) w.delay[i] = dly;
    return w;
  endfunction

  // Build a random tick word that requests mode m. With slow set, draw delays
  // from the realistic range so manual countdowns run for thousands of ticks.
  function automatic mctos_item_t make_tick(mctos_mode_e m, bit slow);
    mctos_item_t w;
    int          pick;
    w.strict_switch = (m == MODE_STRICT);
    // Strict must win whatever the expo switch says.
    w.expo_switch   = (m == MODE_EXPO) || (m == MODE_STRICT && $urandom_range(1) == 1);
    pick = $urandom_range(99);
    if (m == MODE_MANUAL && pick < 70) begin
      // Leave the switches alone so the countdowns decide.
      w.off_switches = '0;
      w.on_switches  = '0;
    end else if (pick < 85) begin
      w.off_switches = NUM_OUT'($urandom & $urandom);
      w.on_switches  = NUM_OUT'($urandom & $urandom);
    end else begin
      w.off_switches = NUM_OUT'($urandom);
      w.on_switches  = NUM_OUT'($urandom);
    end
    for (int i = 0; i < NUM_OUT; i++) begin
      pick = $urandom_range(99);
      if (slow)           w.delay[i] = DELAY_W'($urandom_range(5000, 7000));
      else if (pick < 60) w.delay[i] = DELAY_W'($urandom_range(0, 12));
      else if (pick < 70) w.delay[i] = '0;
      else                w.delay[i] = DELAY_W'($urandom_range(0, 65535));
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic push_tick(mctos_item_t w);
    while (calm_left == 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    strict_switch_i <= w.strict_switch;
    expo_switch_i   <= w.expo_switch;
    off_switches_i  <= w.off_switches;
    on_switches_i   <= w.on_switches;
    delay_0_i       <= w.delay[0];
    delay_1_i       <= w.delay[1];
    delay_2_i       <= w.delay[2];
    delay_3_i       <= w.delay[3];
    delay_4_i       <= w.delay[4];
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Keep one mode requested for n ticks.
  task automatic hold_mode(mctos_mode_e m, int n, bit slow);
    repeat (n) push_tick(make_tick(m, slow));
  endtask

  // Drop valid and wait until every predicted word has come back, then let
  // the two pipeline stages settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both periods; only call this while the block is drained.
  task automatic program_periods(int strict_s, int expo_s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_STRICT_PERIOD;
    cfg_data_i <= PERIOD_W'(strict_s);
    @(posedge clk_i);
    cfg_idx_i  <= REG_EXPO_PERIOD;
    cfg_data_i <= PERIOD_W'(expo_s);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly short mode segments with random content; one in ten is a longer
  // dwell. Every segment counts toward the word target.
  task automatic random_segments(int short_target, int max_dwell);
    int          done;
    int          len;
    mctos_mode_e m;
    done = 0;
    while (done < short_target) begin
      m = mctos_mode_e'($urandom_range(2));
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(20, max_dwell);
      end else begin
        len = $urandom_range(1, 8);
      end
      done += len;
      hold_mode(m, len, 1'b0);
      // Pause the sender now and then until the result channel is empty.
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni        <= 1'b1;
    send_idle_pct <= 18;
    recv_idle_pct <= 78;
    @(posedge clk_i);

    // Directed ticks at the reset periods.
    // Countdowns start expired: every free output toggles on in the first tick.
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd0));
    // Zero delay: toggle on every following tick.
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd0));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd0));
    // Off beats on.
    push_tick(directed_word(1'b0, 1'b0, 5'h1f, 5'h1f, 16'd0));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h1f, 16'hffff));
    push_tick(directed_word(1'b0, 1'b0, 5'h15, 5'h0a, 16'd39999));
    // Expired countdowns reload to the largest delay.
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'hffff));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd5000));
    // Strict wins over expo; schedule modes ignore the switches.
    push_tick(directed_word(1'b1, 1'b1, 5'h1f, 5'h1f, 16'd5000));
    push_tick(directed_word(1'b1, 1'b0, 5'h00, 5'h00, 16'hffff));
    // Enter expo; its first entry fires on the next tick.
    push_tick(directed_word(1'b0, 1'b1, 5'h00, 5'h00, 16'd0));
    push_tick(directed_word(1'b0, 1'b1, 5'h1f, 5'h00, 16'd0));
    push_tick(directed_word(1'b0, 1'b1, 5'h00, 5'h1f, 16'd0));
    // Enter manual: only the switches act in that tick.
    push_tick(directed_word(1'b0, 1'b0, 5'h01, 5'h02, 16'd0));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd3));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd3));
    push_tick(directed_word(1'b1, 1'b0, 5'h00, 5'h00, 16'd0));
    push_tick(directed_word(1'b0, 1'b0, 5'h00, 5'h00, 16'd0));
    random_segments(60, 40);

    // Zero periods: every schedule restarts in each tick after entry.
    wait_drained();
    program_periods(0, 0);
    random_segments(50, 40);

    // Flip the idle rates: slow sender, eager receiver.
    send_idle_pct <= 78;
    recv_idle_pct <= 18;
    wait_drained();
    program_periods(4095, 1);
    random_segments(50, 40);
    wait_drained();
    program_periods(1, 4095);
    random_segments(50, 40);

    // No idling from here on.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    wait_drained();
    program_periods(6, 11);
    hold_mode(MODE_MANUAL, 1, 1'b0);
    hold_mode(MODE_STRICT, 30, 1'b0);
    hold_mode(MODE_EXPO, 30, 1'b0);
    hold_mode(MODE_MANUAL, 30, 1'b1);
    random_segments(40, 40);

    // Short dwells at the reset periods again.
    wait_drained();
    program_periods(45, 600);
    hold_mode(MODE_MANUAL, 1, 1'b0);
    hold_mode(MODE_STRICT, 10, 1'b0);
    hold_mode(MODE_EXPO, 10, 1'b0);
    random_segments(20, 20);

    wait_drained();
    if (mismatch_count == 0 && pending_words == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mctos_pkg.sv
hw/rtl/mctos_in_stage.sv
hw/rtl/mctos_core.sv
hw/rtl/multi_channel_timed_output_sequencer_unit.sv
test/multi_channel_timed_output_sequencer_checker.sv
test/multi_channel_timed_output_sequencer_unit_tb.sv
